// File: src/aedm_pkg.sv
`timescale 1ns / 1ps
package aedm_pkg;

  localparam int MAX_DELAY_DEF   = 16384;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration register layout
  localparam int DELAY_W    = 15;
  localparam int DIV_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELAY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIVISOR = 1'b1;

  localparam logic [DELAY_W-1:0] DELAY_RESET   = 15'd8000;
  localparam logic [DIV_W-1:0]   DIVISOR_RESET = 16'd4;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // beat taken on the input channel this cycle
    logic finish;  // commit the result and update the echo state
  } aedm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
  } aedm_sts_t;

endpackage

// File: src/aedm_ram.sv
`timescale 1ns / 1ps
module aedm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/aedm_div.sv
`timescale 1ns / 1ps
module aedm_div import aedm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [SAMPLE_BITS-1:0]        dividend,
  input  logic                          negate,
  input  logic [DIV_W-1:0]              divisor,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] quotient
);

  localparam int CW = $clog2(SAMPLE_BITS);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [SAMPLE_BITS-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0]       rem_r, rem_nxt;
  logic [DIV_W-1:0]       dvs_r;
  logic                   neg_r;
  logic [DIV_W:0]         rem_sh;
  logic                   fits;

  // One quotient bit a cycle, restoring form
  assign rem_sh = {rem_r, quo_r[SAMPLE_BITS-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SAMPLE_BITS-2:0], fits};
      rem_nxt = fits ? DIV_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIV_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(SAMPLE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
      neg_r <= negate;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

  a_start_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && cnt_r == '0))
    else $error("divider did not begin a fresh run after start");

endmodule

// File: src/aedm_dp.sv
`timescale 1ns / 1ps
module aedm_dp import aedm_pkg::*; #(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_idx,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_action,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  aedm_cmd_t                     cmd,
  output aedm_sts_t                     sts,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_tail_last
);

  localparam int PW = $clog2(MAX_DELAY);
  localparam int AW = $clog2(3 * MAX_DELAY);

  logic [DELAY_W-1:0]     delay_r;
  logic [DIV_W-1:0]       divisor_r;
  logic [PW-1:0]          wp_r, wp_nxt;
  logic [DELAY_W-1:0]     ti_r, ti_nxt;
  logic [DELAY_W-1:0]     dc_r, dc_nxt;
  logic                   action_r;
  logic [SAMPLE_BITS-1:0] x_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic                   out_tail_last_r;

  logic [DELAY_W-1:0]     d_eff;
  logic [DIV_W-1:0]       dvs_eff;
  logic [DELAY_W-1:0]     t_sat;
  logic                   echo_live;
  logic                   tail_echo;
  logic                   tail_end;
  logic [AW-1:0]          addr_sum;
  logic [PW-1:0]          raddr;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   div_start;
  logic signed [SAMPLE_BITS-1:0] quo;
  logic                   ring_we;

  // Effective delay: zero acts as one, clamp to ring depth
  always_comb begin
    d_eff = delay_r;
    priority if (delay_r == '0) begin
      d_eff = DELAY_W'(1);
    end else if (32'(delay_r) > MAX_DELAY) begin
      d_eff = DELAY_W'(MAX_DELAY);
    end else begin
      d_eff = delay_r;
    end
  end

  assign dvs_eff   = (divisor_r == '0) ? DIV_W'(1) : divisor_r;
  assign t_sat     = (ti_r < d_eff) ? ti_r : d_eff;
  assign echo_live = ti_r >= d_eff;
  assign tail_echo = ({1'b0, dc_r} + {1'b0, t_sat}) >= {1'b0, d_eff};
  assign tail_end  = ({1'b0, dc_r} + (DELAY_W + 1)'(1)) >= {1'b0, d_eff};

  // Ring read address: wp - d (+ drain offset), folded back into the ring
  always_comb begin
    addr_sum = AW'(wp_r) + AW'(MAX_DELAY) - AW'(d_eff) + (in_action ? AW'(dc_r) : '0);
    priority if (addr_sum >= AW'(2 * MAX_DELAY)) begin
      raddr = PW'(addr_sum - AW'(2 * MAX_DELAY));
    end else if (addr_sum >= AW'(MAX_DELAY)) begin
      raddr = PW'(addr_sum - AW'(MAX_DELAY));
    end else begin
      raddr = PW'(addr_sum);
    end
  end

  assign mag       = in_sample_in[SAMPLE_BITS-1] ? (~in_sample_in + 1'b1) : in_sample_in;
  assign div_start = cmd.accept && !in_action;
  assign ring_we   = cmd.finish && !action_r;

  aedm_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .negate   (in_sample_in[SAMPLE_BITS-1]),
    .divisor  (dvs_eff),
    .done     (sts.div_done),
    .quotient (quo)
  );

  aedm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_DELAY)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp_r),
    .wdata (quo),
    .re    (cmd.accept),
    .raddr (raddr),
    .rdata (ring_rdata)
  );

  always_comb begin
    wp_nxt = wp_r;
    ti_nxt = ti_r;
    dc_nxt = dc_r;
    if (cmd.finish) begin
      if (!action_r) begin
        wp_nxt = (wp_r == PW'(MAX_DELAY - 1)) ? '0 : wp_r + 1'b1;
        if (echo_live == 1'b0) begin
          ti_nxt = ti_r + 1'b1;
        end
        dc_nxt = '0;
      end else if (tail_end) begin
        wp_nxt = '0;
        ti_nxt = '0;
        dc_nxt = '0;
      end else begin
        dc_nxt = dc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r   <= DELAY_RESET;
      divisor_r <= DIVISOR_RESET;
      wp_r      <= '0;
      ti_r      <= '0;
      dc_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_IDX_DELAY:   delay_r   <= cfg_wdata[DELAY_W-1:0];
          CFG_IDX_DIVISOR: divisor_r <= cfg_wdata[DIV_W-1:0];
          default: ;
        endcase
      end
      wp_r <= wp_nxt;
      ti_r <= ti_nxt;
      dc_r <= dc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= in_action;
      x_r      <= in_sample_in;
    end
    if (cmd.finish) begin
      if (!action_r) begin
        out_sample_r    <= x_r + (echo_live ? ring_rdata : '0);
        out_tail_last_r <= 1'b0;
      end else begin
        out_sample_r    <= tail_echo ? ring_rdata : '0;
        out_tail_last_r <= tail_end;
      end
    end
  end

  assign out_sample_out = out_sample_r;
  assign out_tail_last  = out_tail_last_r;

endmodule

// File: src/aedm_ctrl.sv
`timescale 1ns / 1ps
module aedm_ctrl import aedm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  aedm_sts_t sts,
  output aedm_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;
  logic       finish;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign finish   = out_free && (((state_r == ST_DIV) && sts.div_done) || (state_r == ST_FIN));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_action ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = finish ? ST_IDLE : ST_FIN;
        end
      end
      ST_FIN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign cmd.accept = accept;
  assign cmd.finish = finish;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (!out_valid_r || out_ready))
    else $error("result committed over a beat still waiting");

  a_drain_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action) |=> (state_r == ST_FIN))
    else $error("drain tick did not go straight to finish");

endmodule

// File: src/audio_echo_delay_mixer_core.sv
`timescale 1ns / 1ps
// Feedforward comb echo: out = in + delayed(in) / divisor, wrapped to the sample width.
// Input channel (in_valid/in_ready): in_action = 0 carries a PCM sample in in_sample_in,
// in_action = 1 is a drain tick that emits one item of the echo tail after the clip.
// Output channel (out_valid/out_ready): exactly one beat per input beat, in order;
// out_tail_last marks the final tail item, after which the echo state is back at start.
// Configuration (cfg_we/cfg_idx/cfg_wdata): index 0 is the delay in samples, index 1 the
// divisor; write only while no item is in flight.
// Path: a sample beat reaches the result register once the bit-serial divider, which scales
// the sample before it enters the echo ring, is done; a drain beat reaches it after a single
// ring read.
// Issue: the next beat can be accepted the cycle after the previous result is registered,
// even if that result still waits downstream; no beat is taken while one is in progress.
// Stall: if out_ready is low, the result register holds its beat; a finished item waits
// and in_ready stays low until the register frees up.
// Reset (synchronous, rst_n low): delay 8000, divisor 4, write pointer, sample count and
// drain count cleared. The ring itself is not cleared, so no clearing pass is needed.
module audio_echo_delay_mixer_core import aedm_pkg::*; #(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_idx,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_tail_last
);

  aedm_cmd_t cmd;
  aedm_sts_t sts;

  // Sequencing: idle, divide, finish
  aedm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Config registers, echo ring, divider and result register
  aedm_dp #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_action      (in_action),
    .in_sample_in   (in_sample_in),
    .cmd            (cmd),
    .sts            (sts),
    .out_sample_out (out_sample_out),
    .out_tail_last  (out_tail_last)
  );

endmodule

// File: tb/sv/audio_echo_delay_mixer_core_test.sv
`timescale 1ns / 1ps
module audio_echo_delay_mixer_core_test;
  import aedm_pkg::*;

  localparam int SW   = SAMPLE_BITS_DEF;
  localparam int RING = MAX_DELAY_DEF;

  // What one input beat asks for
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  // Cycles with no beat on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // Beats of random traffic per configuration setting (3 idling modes x 4 settings)
  localparam int BEATS_PER_SETTING = 88;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 last;
  } echo_out_t;

  typedef struct {
    logic                 action;
    logic signed [SW-1:0] sample;
    bit                   hold;   // present only once every earlier result is back
    echo_out_t            want;
  } echo_beat_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx      = CFG_IDX_DELAY;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic                 in_action    = ACT_SAMPLE;
  logic signed [SW-1:0] in_sample_in = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic signed [SW-1:0] out_sample_out;
  logic                 out_tail_last;

  audio_echo_delay_mixer_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_tail_last (out_tail_last)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Echo predictor: its own copy of the registers and of the echo state.
  // ---------------------------------------------------------------------------
  logic [DELAY_W-1:0]   dly_reg = DELAY_RESET;
  logic [DIV_W-1:0]     div_reg = DIVISOR_RESET;
  logic signed [SW-1:0] echo_mem [0:RING-1];
  bit                   echo_written [0:RING-1];   // slots holding a scaled sample
  logic [13:0]          wr_ptr   = '0;
  logic [14:0]          smp_seen = '0;              // samples so far, saturating at the delay
  logic [14:0]          tail_pos = '0;              // tail beats already emitted

  echo_beat_t pending_beats[$];   // beats waiting for the driver
  echo_out_t  echo_due[$];        // results owed by the block, oldest first
  int         beats_queued  = 0;
  bit         tail_closed   = 1'b0;
  int         send_idle_pct = 9;
  int         recv_idle_pct = 76;
  int         fault_count   = 0;
  int         stall_cycles  = 0;

  // A delay of zero acts as one; anything past the ring depth is clamped to it
  function automatic int eff_delay();
    int d;
    d = dly_reg;
    if (d == 0) d = 1;
    if (d > RING) d = RING;
    return d;
  endfunction

  function automatic int eff_divisor();
    return (div_reg == 0) ? 1 : int'(div_reg);
  endfunction

  // Ring slot a drain tick reads, or -1 while the tail is still in its zero run
  function automatic int drain_tap();
    int d, k, t;
    d = eff_delay();
    k = tail_pos;
    t = (smp_seen < d) ? int'(smp_seen) : d;
    if (k + t >= d) return (int'(wr_ptr) + RING - d + k) % RING;
    return -1;
  endfunction

  function automatic echo_out_t echo_mix_step(logic act, logic signed [SW-1:0] x);
    echo_out_t r;
    int        d, y, q, tap;
    d = eff_delay();
    if (act == ACT_SAMPLE) begin
      // a sample always cancels any drain in progress
      tail_pos = '0;
      y = x;
      if (smp_seen >= d) y = y + echo_mem[(int'(wr_ptr) + RING - d) % RING];
      q = int'(x) / eff_divisor();
      echo_mem[wr_ptr]     = q[SW-1:0];
      echo_written[wr_ptr] = 1'b1;
      wr_ptr = wr_ptr + 1'b1;
      if (smp_seen < d) smp_seen = smp_seen + 1'b1;
      r.sample = y[SW-1:0];
      r.last   = 1'b0;
    end else begin
      tap      = drain_tap();
      r.sample = (tap >= 0) ? echo_mem[tap] : '0;
      r.last   = (int'(tail_pos) + 1 >= d);
      if (r.last) begin
        // tail complete: back to the start state, ring contents kept
        wr_ptr   = '0;
        smp_seen = '0;
        tail_pos = '0;
      end else begin
        tail_pos = tail_pos + 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Predict and queue one beat. A drain tick that would read a ring slot never
  // written (only possible after the delay shrinks mid-drain) becomes a sample.
  task automatic queue_beat(input logic act, input logic signed [SW-1:0] x, input bit hold);
    echo_beat_t b;
    int         tap;
    if (act == ACT_DRAIN) begin
      tap = drain_tap();
      if (tap >= 0 && !echo_written[tap]) act = ACT_SAMPLE;
    end
    b.action = act;
    b.sample = x;
    b.hold   = hold;
    b.want   = echo_mix_step(act, x);
    tail_closed = b.want.last;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  function automatic logic signed [SW-1:0] rand_pcm();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return SW'($urandom_range(0, 31) - 16);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'h8000 | 16'($urandom_range(1, 12));   // top bit is dropped
      2:       return 16'($urandom_range(25, 64));
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_divisor();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      3:       return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(2, 9));
    endcase
  endfunction

  // One clip and its tail, a clip cut short by a sample mid-tail, or plain noise
  task automatic queue_sequence(input int lim);
    int d, n, kind;
    d    = eff_delay();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) if (beats_queued < lim) queue_beat(1'($urandom_range(0, 1)), rand_pcm(), 1'b0);
    end else begin
      n = $urandom_range(0, 2 * d + 4);
      repeat (n) begin
        if (beats_queued < lim)
          queue_beat(ACT_SAMPLE, rand_pcm(), $urandom_range(0, 79) == 0);
      end
      if (kind <= 2) begin
        n = $urandom_range(1, d);
        repeat (n) if (beats_queued < lim) queue_beat(ACT_DRAIN, rand_pcm(), 1'b0);
        if (beats_queued < lim) queue_beat(ACT_SAMPLE, rand_pcm(), 1'b0);
      end else begin
        tail_closed = 1'b0;
        while (beats_queued < lim && !tail_closed) queue_beat(ACT_DRAIN, rand_pcm(), 1'b0);
      end
    end
  endtask

  // Hold until every queued beat is accepted and every result has come back
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || echo_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_DELAY) dly_reg = data[DELAY_W-1:0];
    else div_reg = data[DIV_W-1:0];
  endtask

  task automatic log_fault(input string msg);
    if (fault_count < 10) $display("%0t ns: %s", $time, msg);
    fault_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the oldest pending beat, keep it steady until taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        echo_due.push_back(pending_beats[0].want);
        pending_beats.pop_front();
      end
      // only choose afresh when nothing is held on the channel
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(pending_beats[0].hold && echo_due.size() != 0)) begin
          in_valid     <= 1'b1;
          in_action    <= pending_beats[0].action;
          in_sample_in <= pending_beats[0].sample;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    echo_out_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (echo_due.size() == 0) begin
          log_fault($sformatf("unexpected beat: sample %0d last %0b",
                              out_sample_out, out_tail_last));
        end else begin
          w = echo_due.pop_front();
          if (out_sample_out !== w.sample || out_tail_last !== w.last)
            log_fault($sformatf("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                                w.sample, w.last, out_sample_out, out_tail_last));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles in a row with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: directed cases, then random traffic under three idling modes.
  // ---------------------------------------------------------------------------
  initial begin
    int lim;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, delay far beyond the clip: extremes pass straight through,
    // a lone drain tick gives zero, and a sample cancels that drain. Pause the
    // last one until everything earlier is back.
    queue_beat(ACT_SAMPLE, 16'h7FFF, 1'b0);
    queue_beat(ACT_SAMPLE, 16'h8000, 1'b0);
    queue_beat(ACT_SAMPLE, 16'h0000, 1'b0);
    queue_beat(ACT_SAMPLE, 16'hFFFF, 1'b0);
    queue_beat(ACT_SAMPLE, 16'h0001, 1'b0);
    queue_beat(ACT_DRAIN,  16'hA5A5, 1'b0);
    queue_beat(ACT_SAMPLE, 16'h1234, 1'b1);
    wait_idle();

    // Delay with every data bit set clamps to the ring depth; divisor zero acts as one
    write_reg(CFG_IDX_DELAY,   16'hFFFF);
    write_reg(CFG_IDX_DIVISOR, 16'h0000);
    queue_beat(ACT_SAMPLE, 16'h8000, 1'b0);
    queue_beat(ACT_SAMPLE, 16'h7FFF, 1'b0);
    queue_beat(ACT_DRAIN,  16'h5A5A, 1'b0);
    wait_idle();

    // Shrink the delay mid-clip: the sample count already exceeds it, so the echo
    // is immediate. Largest divisor, then a whole three-beat tail.
    write_reg(CFG_IDX_DELAY,   16'd3);
    write_reg(CFG_IDX_DIVISOR, 16'hFFFF);
    queue_beat(ACT_SAMPLE, 16'h8000, 1'b0);
    queue_beat(ACT_SAMPLE, 16'h7FFF, 1'b0);
    repeat (3) queue_beat(ACT_DRAIN, 16'h0000, 1'b0);
    wait_idle();

    // Delay zero acts as one: drain with no samples is a single flagged zero
    write_reg(CFG_IDX_DELAY,   16'd0);
    write_reg(CFG_IDX_DIVISOR, 16'd1);
    queue_beat(ACT_DRAIN,  16'hFFFF, 1'b0);
    queue_beat(ACT_SAMPLE, 16'h4000, 1'b0);
    queue_beat(ACT_SAMPLE, 16'hC000, 1'b0);
    wait_idle();

    // Grow the delay mid-clip, then stop part way through the tail
    write_reg(CFG_IDX_DELAY,   16'd4);
    write_reg(CFG_IDX_DIVISOR, 16'd3);
    queue_beat(ACT_SAMPLE, 16'h7FFD, 1'b0);
    queue_beat(ACT_SAMPLE, 16'h8001, 1'b0);
    queue_beat(ACT_SAMPLE, 16'hFFFE, 1'b0);
    repeat (2) queue_beat(ACT_DRAIN, 16'h0000, 1'b0);
    wait_idle();

    // Shrink the delay mid-drain: the next tick closes the tail
    write_reg(CFG_IDX_DELAY, 16'd3);
    queue_beat(ACT_DRAIN, 16'h0000, 1'b0);

    for (int m = 0; m < 3; m++) begin
      wait_idle();
      send_idle_pct = (m == 0) ? 9 : (m == 1) ? 76 : 0;
      recv_idle_pct = (m == 0) ? 76 : (m == 1) ? 9 : 0;
      for (int p = 0; p < 4; p++) begin
        wait_idle();
        write_reg(CFG_IDX_DELAY,   pick_delay());
        write_reg(CFG_IDX_DIVISOR, pick_divisor());
        lim = beats_queued + BEATS_PER_SETTING;
        while (beats_queued < lim) queue_sequence(lim);
      end
    end

    wait_idle();
    // allow a late stray beat to show up before judging
    repeat (40) @(posedge clk);
    if (fault_count == 0 && echo_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
